>>> design/mono_glyph_pixel_expander_assert.svh
// Assertion macros used by the checker file of the glyph expander.
// Every macro expects signals named clk and rst_n in the scope where it is used.
`ifndef MONO_GLYPH_PIXEL_EXPANDER_ASSERT_SVH
`define MONO_GLYPH_PIXEL_EXPANDER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MGPE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MGPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after reset is sampled active.
`define MGPE_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error(msg);

`endif

>>> design/mgpe_pkg.sv
package mgpe_pkg;

  localparam int IDX_W     = 22;
  localparam int COLOR_W   = 32;
  localparam int CFG_AW    = 5;
  localparam int CFG_DW    = 32;
  localparam int PIX_PER_B = 8;

  localparam logic [11:0] GLYPH_ROW_MAX = 12'd4095;

  localparam logic [1:0] FMT_RGB888 = 2'd0;
  localparam logic [1:0] FMT_RGB565 = 2'd1;
  localparam logic [1:0] FMT_NONE   = 2'd2;

  typedef enum logic [2:0] {
    REG_FB_WIDTH  = 3'd0,
    REG_FB_HEIGHT = 3'd1,
    REG_PIX_FMT   = 3'd2,
    REG_ORIGIN_X  = 3'd3,
    REG_ORIGIN_Y  = 3'd4,
    REG_ROW_BYTES = 3'd5,
    REG_FG_COLOR  = 3'd6,
    REG_BG_COLOR  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] glyph_byte;
    logic       glyph_end;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]   pixel_index;
    logic [COLOR_W-1:0] pixel_color;
    logic               run_last;
  } out_item_t;

  typedef struct packed {
    logic [11:0]        fb_width;
    logic [11:0]        fb_height;
    logic [1:0]         pixel_format;
    logic [10:0]        origin_x;
    logic [10:0]        origin_y;
    logic [4:0]         row_bytes;
    logic [COLOR_W-1:0] fg_color;
    logic [COLOR_W-1:0] bg_color;
  } cfg_t;

  // One classified glyph byte waiting for the expander.
  typedef struct packed {
    logic [IDX_W-1:0] row_base;
    logic [IDX_W-1:0] base_col;
    logic [7:0]       bits;
    logic [7:0]       mask;
  } entry_t;

endpackage

>>> design/mgpe_regs.sv
module mgpe_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [mgpe_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [mgpe_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [mgpe_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                      cfg_pready,
  output mgpe_pkg::cfg_t            cfg
);
  import mgpe_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx        = reg_idx_t'(cfg_paddr[CFG_AW-1:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_FB_WIDTH:  cfg_nxt.fb_width     = cfg_pwdata[11:0];
        REG_FB_HEIGHT: cfg_nxt.fb_height    = cfg_pwdata[11:0];
        REG_PIX_FMT:   cfg_nxt.pixel_format = cfg_pwdata[1:0];
        REG_ORIGIN_X:  cfg_nxt.origin_x     = cfg_pwdata[10:0];
        REG_ORIGIN_Y:  cfg_nxt.origin_y     = cfg_pwdata[10:0];
        REG_ROW_BYTES: cfg_nxt.row_bytes    = cfg_pwdata[4:0];
        REG_FG_COLOR:  cfg_nxt.fg_color     = cfg_pwdata;
        REG_BG_COLOR:  cfg_nxt.bg_color     = cfg_pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FB_WIDTH:  cfg_prdata = CFG_DW'(cfg_r.fb_width);
      REG_FB_HEIGHT: cfg_prdata = CFG_DW'(cfg_r.fb_height);
      REG_PIX_FMT:   cfg_prdata = CFG_DW'(cfg_r.pixel_format);
      REG_ORIGIN_X:  cfg_prdata = CFG_DW'(cfg_r.origin_x);
      REG_ORIGIN_Y:  cfg_prdata = CFG_DW'(cfg_r.origin_y);
      REG_ROW_BYTES: cfg_prdata = CFG_DW'(cfg_r.row_bytes);
      REG_FG_COLOR:  cfg_prdata = cfg_r.fg_color;
      REG_BG_COLOR:  cfg_prdata = cfg_r.bg_color;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fb_width     <= 12'd800;
      cfg_r.fb_height    <= 12'd480;
      cfg_r.pixel_format <= FMT_RGB888;
      cfg_r.origin_x     <= 11'd0;
      cfg_r.origin_y     <= 11'd0;
      cfg_r.row_bytes    <= 5'd2;
      cfg_r.fg_color     <= 32'h00FF_FFFF;
      cfg_r.bg_color     <= 32'h0000_0000;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> design/mgpe_front.sv
module mgpe_front #(
  parameter int MAX_DIM       = 2048,
  parameter int MAX_ROW_BYTES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mgpe_pkg::cfg_t     cfg,
  input  logic               in_valid,
  output logic               in_stall,
  input  mgpe_pkg::in_item_t in_data,
  output logic               q_push,
  output mgpe_pkg::entry_t   q_wdata,
  input  logic               q_full
);
  import mgpe_pkg::*;

  localparam int DIMW  = ($clog2(MAX_DIM + 1) > 12) ? $clog2(MAX_DIM + 1) : 12;
  localparam int COLW  = $clog2(2048 + 8 * MAX_ROW_BYTES);
  localparam int PW0   = (DIMW > 13) ? DIMW : 13;
  localparam int PW    = (COLW > PW0) ? COLW : PW0;
  localparam int BCW   = $clog2(MAX_ROW_BYTES + 1);
  localparam int RBW   = ((BCW > 5) ? BCW : 5) + 1;

  logic [BCW-1:0]  byte_col_r, byte_col_nxt;
  logic [11:0]     glyph_row_r, glyph_row_nxt;
  logic            s1_valid_r, s1_valid_nxt;
  logic [PW-1:0]   s1_row_r;
  logic [PW-1:0]   s1_base_r;
  logic [7:0]      s1_bits_r;
  logic [7:0]      s1_mask_r;

  logic [DIMW-1:0] width_eff, height_eff;
  logic [RBW-1:0]  rb_eff, col_inc;
  logic [PW-1:0]   row, base;
  logic            row_ok;
  logic [7:0]      mask;
  logic            accept, s1_drain;
  logic [PW+DIMW-1:0] prod;

  always_comb begin
    width_eff  = (DIMW'(cfg.fb_width) > DIMW'(MAX_DIM)) ? DIMW'(MAX_DIM)
                                                         : DIMW'(cfg.fb_width);
    height_eff = (DIMW'(cfg.fb_height) > DIMW'(MAX_DIM)) ? DIMW'(MAX_DIM)
                                                          : DIMW'(cfg.fb_height);
    priority if (cfg.row_bytes == 5'd0)
      rb_eff = RBW'(1);
    else if (RBW'(cfg.row_bytes) > RBW'(MAX_ROW_BYTES))
      rb_eff = RBW'(MAX_ROW_BYTES);
    else
      rb_eff = RBW'(cfg.row_bytes);
  end

  // Classify the byte: which of its eight pixels land inside the framebuffer.
  always_comb begin
    row    = PW'(cfg.origin_y) + PW'(glyph_row_r);
    base   = PW'(cfg.origin_x) + (PW'(byte_col_r) << 3);
    row_ok = (cfg.pixel_format == FMT_RGB888 || cfg.pixel_format == FMT_RGB565) &&
             (row < PW'(height_eff));
    for (int j = 0; j < PIX_PER_B; j++) begin
      mask[j] = row_ok && ((base + PW'(j)) < PW'(width_eff));
    end
  end

  // Bytes with nothing to write leave stage one without entering the queue.
  assign s1_drain = !q_full || (s1_mask_r == 8'd0);
  assign in_stall = s1_valid_r && !s1_drain;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    col_inc       = RBW'(byte_col_r) + RBW'(1);
    byte_col_nxt  = byte_col_r;
    glyph_row_nxt = glyph_row_r;
    if (accept) begin
      priority if (in_data.glyph_end) begin
        byte_col_nxt  = '0;
        glyph_row_nxt = '0;
      end else if (col_inc >= rb_eff) begin
        byte_col_nxt = '0;
        if (glyph_row_r < GLYPH_ROW_MAX) glyph_row_nxt = glyph_row_r + 12'd1;
      end else begin
        byte_col_nxt = col_inc[BCW-1:0];
      end
    end
    priority if (accept) s1_valid_nxt = 1'b1;
    else if (s1_drain)   s1_valid_nxt = 1'b0;
    else                 s1_valid_nxt = s1_valid_r;
  end

  always_comb begin
    prod             = (PW+DIMW)'(s1_row_r) * (PW+DIMW)'(width_eff);
    q_push           = s1_valid_r && (s1_mask_r != 8'd0) && !q_full;
    q_wdata.row_base = prod[IDX_W-1:0];
    q_wdata.base_col = IDX_W'(s1_base_r);
    q_wdata.bits     = s1_bits_r;
    q_wdata.mask     = s1_mask_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_col_r  <= '0;
      glyph_row_r <= '0;
      s1_valid_r  <= 1'b0;
    end else begin
      byte_col_r  <= byte_col_nxt;
      glyph_row_r <= glyph_row_nxt;
      s1_valid_r  <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_row_r  <= row;
      s1_base_r <= base;
      s1_bits_r <= in_data.glyph_byte;
      s1_mask_r <= mask;
    end
  end

endmodule

>>> design/mgpe_queue.sv
module mgpe_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mgpe_pkg::entry_t wdata,
  input  logic             pop,
  output mgpe_pkg::entry_t rdata,
  output logic             full,
  output logic             empty
);
  import mgpe_pkg::*;

  entry_t     slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push, do_pop;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign rdata   = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= wdata;
  end

endmodule

>>> design/mgpe_back.sv
module mgpe_back (
  input  logic                clk,
  input  logic                rst_n,
  input  mgpe_pkg::cfg_t      cfg,
  input  mgpe_pkg::entry_t    q_rdata,
  input  logic                q_empty,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output mgpe_pkg::out_item_t out_data
);
  import mgpe_pkg::*;

  logic      cur_valid_r, cur_valid_nxt;
  entry_t    cur_r, cur_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_r, out_nxt;

  logic [2:0] pick;
  logic [7:0] rest;
  logic       last, emit, load;
  logic [COLOR_W-1:0] color;

  // Leftmost remaining pixel: lowest mask index.
  always_comb begin
    pick = 3'd0;
    for (int j = PIX_PER_B - 1; j >= 0; j--) begin
      if (cur_r.mask[j]) pick = 3'(j);
    end
    rest = cur_r.mask & ~(8'd1 << pick);
    last = (rest == 8'd0);
  end

  assign emit  = cur_valid_r && (!out_valid_r || !out_stall);
  assign load  = (!cur_valid_r || (emit && last)) && !q_empty;
  assign q_pop = load;

  always_comb begin
    color = cur_r.bits[3'd7 - pick] ? cfg.fg_color : cfg.bg_color;
    if (cfg.pixel_format == FMT_RGB565) color = {16'd0, color[15:0]};

    out_nxt.pixel_index = cur_r.row_base + cur_r.base_col + IDX_W'(pick);
    out_nxt.pixel_color = color;
    out_nxt.run_last    = last;

    priority if (emit)   out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
    else                 out_valid_nxt = out_valid_r;

    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    if (emit) begin
      cur_nxt.mask = rest;
      if (last) cur_valid_nxt = 1'b0;
    end
    if (load) begin
      cur_nxt       = q_rdata;
      cur_valid_nxt = 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (emit) out_r <= out_nxt;
  end

endmodule

>>> design/mono_glyph_pixel_expander.sv
// A taken byte passes stage one, the queue and the current-byte register before its first pixel
// write is registered onto out_valid. Throughput: one pixel write per cycle while out_stall is low;
// a byte with n writes keeps the expander busy for all of them (eight for an unclipped byte); this
// is set by the single output port. Fully clipped and unsupported-format bytes skip the expander.
// Reset (rst_n low, synchronous): glyph counters, pipeline, queue and output valid are cleared;
// configuration registers return to 800, 480, rgb888, 0, 0, 2, 0xFFFFFF, 0.
module mono_glyph_pixel_expander #(
  parameter int MAX_DIM       = 2048,
  parameter int MAX_ROW_BYTES = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  mgpe_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output mgpe_pkg::out_item_t         out_data,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [mgpe_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [mgpe_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [mgpe_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);
  import mgpe_pkg::*;

  cfg_t   cfg;
  entry_t q_wdata, q_rdata;
  logic   q_push, q_pop, q_full, q_empty;

  mgpe_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  mgpe_front #(
    .MAX_DIM       (MAX_DIM),
    .MAX_ROW_BYTES (MAX_ROW_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_wdata  (q_wdata),
    .q_full   (q_full)
  );

  mgpe_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  mgpe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_rdata   (q_rdata),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> design/mgpe_checker.sv
`include "mono_glyph_pixel_expander_assert.svh"

module mgpe_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_stall,
  input mgpe_pkg::out_item_t         out_data,
  input logic                        cfg_psel,
  input logic                        cfg_penable,
  input logic                        cfg_pwrite,
  input logic [mgpe_pkg::CFG_AW-1:0] cfg_paddr,
  input logic [mgpe_pkg::CFG_DW-1:0] cfg_pwdata,
  input logic [mgpe_pkg::CFG_DW-1:0] cfg_prdata,
  input logic                        cfg_pready
);
  import mgpe_pkg::*;

  logic fmt_wr, fmt_rd;

  assign fmt_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                  (cfg_paddr[CFG_AW-1:2] == REG_PIX_FMT);
  assign fmt_rd = (cfg_paddr[CFG_AW-1:2] == REG_PIX_FMT);

  `MGPE_ASSERT_RST(a_out_idle_after_reset, !out_valid, "output valid after reset")

  `MGPE_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                    out_valid && $stable(out_data), "stalled output item changed")

  // The pixels of one byte follow each other without a gap.
  `MGPE_ASSERT_NEXT(a_run_continues, out_valid && !out_stall && !out_data.run_last,
                    out_valid, "gap inside the writes of one byte")

  `MGPE_ASSERT_NEXT(a_fmt_readback, fmt_wr,
                    !fmt_rd || cfg_prdata == CFG_DW'($past(cfg_pwdata[1:0])),
                    "pixel format readback mismatch")

endmodule

bind mono_glyph_pixel_expander mgpe_checker u_mgpe_checker (.*);
